// ----- hdl/imuf_pkg.sv -----
package imuf_pkg;

  localparam int FILTER_TAPS_DEF = 5;
  localparam int AXES = 6;
  localparam int GYRO_AXES = 3;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W = 32;
  localparam int ANGLE_W = 32;
  localparam int IN_DATA_W = AXES * SAMPLE_W;
  localparam int OUT_DATA_W = AXES * SAMPLE_W + GYRO_AXES * ANGLE_W;
  localparam int CFG_INDEX_W = 3;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd32786;
  // 0.98 in Q0.16
  localparam logic [15:0] ANGLE_SCALE = 16'd64225;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_OFFSET_X = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_OFFSET_Y = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_OFFSET_Z = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GYRO_OFFSET_X  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GYRO_OFFSET_Y  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_GYRO_OFFSET_Z  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN     = 3'd6;

  // per-cycle stage strobes from the sequencer to the lanes
  typedef struct packed {
    logic load;
    logic filt;
    logic div;
    logic quot;
    logic gmul;
    logic gsum;
    logic integ;
    logic amul;
    logic item_valid;
  } stage_ctl_t;

endpackage

// ----- hdl/imuf_axis_lane.sv -----
module imuf_axis_lane #(
  parameter int FILTER_TAPS = imuf_pkg::FILTER_TAPS_DEF
) (
  input  logic                                 clk,
  input  imuf_pkg::stage_ctl_t                 ctl,
  input  logic signed [imuf_pkg::SAMPLE_W-1:0] raw,
  input  logic signed [imuf_pkg::SAMPLE_W-1:0] offset,
  output logic signed [imuf_pkg::SAMPLE_W-1:0] filt
);

  localparam int HistLen = FILTER_TAPS - 1;
  localparam int TapSum = FILTER_TAPS * (FILTER_TAPS + 1) / 2;
  localparam int MagW = $clog2(TapSum + 1) + 15;
  localparam int SumW = MagW + 1;
  // floor(2^MagW / TapSum): quotient estimate is exact or one low
  localparam logic [MagW-1:0] Recip = MagW'((2 ** MagW) / TapSum);

  logic signed [15:0]     cur;
  logic signed [15:0]     hist [HistLen];
  logic signed [SumW-1:0] sum;
  logic [MagW-1:0]        mag;
  logic                   neg;
  logic [2*MagW-1:0]      prod;

  logic signed [16:0]     diff;
  logic signed [15:0]     corr;
  logic signed [SumW-1:0] sum_next;
  logic signed [SumW-1:0] term;
  logic [MagW-1:0]        abs_sum;
  logic [MagW-1:0]        q_est;
  logic [MagW-1:0]        rem;
  logic [MagW-1:0]        q;
  logic signed [16:0]     q_signed;

  always_comb begin
    diff = 17'(raw) - 17'(offset);
    if (diff > 17'sd32767) begin
      corr = 16'sh7fff;
    end else if (diff < -17'sd32768) begin
      corr = 16'sh8000;
    end else begin
      corr = diff[15:0];
    end
  end

  always_comb begin
    sum_next = SumW'(FILTER_TAPS) * SumW'(cur);
    for (int k = 0; k < HistLen; k++) begin
      term = SumW'(FILTER_TAPS - 1 - k) * SumW'(hist[k]);
      sum_next = sum_next + term;
    end
  end

  always_comb begin
    abs_sum = MagW'(sum[SumW-1] ? -sum : sum);
    q_est = prod[2*MagW-1:MagW];
    rem = mag - MagW'(q_est * TapSum);
    q = (rem >= MagW'(TapSum)) ? q_est + MagW'(1) : q_est;
    q_signed = neg ? -17'(q) : 17'(q);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cur <= corr;
    end
    if (ctl.filt) begin
      sum <= sum_next;
      hist[0] <= cur;
      for (int k = 1; k < HistLen; k++) begin
        hist[k] <= hist[k-1];
      end
    end
    if (ctl.div) begin
      neg <= sum[SumW-1];
      mag <= abs_sum;
      prod <= (2*MagW)'(abs_sum) * (2*MagW)'(Recip);
    end
    if (ctl.quot) begin
      filt <= ctl.item_valid ? q_signed[15:0] : 16'sd0;
    end
  end

endmodule

// ----- hdl/imuf_gyro_integ.sv -----
module imuf_gyro_integ (
  input  logic                                 clk,
  input  logic                                 rst,
  input  imuf_pkg::stage_ctl_t                 ctl,
  input  logic signed [imuf_pkg::SAMPLE_W-1:0] filt,
  input  logic [imuf_pkg::GAIN_W-1:0]          gain,
  output logic signed [imuf_pkg::ANGLE_W-1:0]  angle
);

  logic signed [15:0] prev;
  logic signed [33:0] plo;
  logic signed [33:0] phi;
  logic signed [63:0] inc;
  logic signed [63:0] integ;
  logic signed [33:0] ml;
  logic signed [33:0] mh;
  logic               in_range;
  logic               sign;

  logic signed [16:0] s;
  logic signed [64:0] wide;
  logic signed [63:0] integ_next;
  logic signed [50:0] scaled;
  logic signed [34:0] p;

  assign s = 17'(filt) + 17'(prev);

  // saturating 64-bit accumulate
  always_comb begin
    wide = 65'(integ) + 65'(inc);
    if (wide[64] != wide[63]) begin
      integ_next = wide[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      integ_next = wide[63:0];
    end
  end

  // when in_range, integ >>> 17 fits 33 bits: split into signed high and unsigned low halves
  always_comb begin
    scaled = (51'(mh) <<< 16) + 51'(ml) + 51'sd32768;
    p = scaled[50:16];
    if (!in_range) begin
      angle = sign ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else if (p > 35'sh07fffffff) begin
      angle = {1'b0, {31{1'b1}}};
    end else if (p < -35'sh080000000) begin
      angle = {1'b1, 31'd0};
    end else begin
      angle = p[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
      integ <= '0;
    end else begin
      if (ctl.gmul) begin
        prev <= filt;
      end
      if (ctl.integ) begin
        integ <= integ_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.gmul) begin
      plo <= s * $signed({1'b0, gain[15:0]});
      phi <= s * $signed({1'b0, gain[31:16]});
    end
    if (ctl.gsum) begin
      inc <= 64'(plo) + (64'(phi) <<< 16);
    end
    if (ctl.amul) begin
      in_range <= (integ[63:49] == {15{integ[49]}});
      sign <= integ[63];
      mh <= $signed(integ[49:33]) * $signed({1'b0, imuf_pkg::ANGLE_SCALE});
      ml <= $signed({1'b0, integ[32:17]}) * $signed({1'b0, imuf_pkg::ANGLE_SCALE});
    end
  end

endmodule

// ----- hdl/imu_weighted_filter_integrator.sv -----
// The sequencer walks one sample at a time through filter sum, reciprocal divide, gain multiply,
//   integrate and 0.98 scaling (FILT, DIV, QUOT, GMUL, GSUM, INTEG, AMUL, OUT); m_tvalid is
//   registered when OUT finds the output slot free, and only then is a new sample accepted.
// A finished result waits in the output register while the next sample is taken in.
// Reset (rst, synchronous): offsets 0, gain 32786, integrators and sample count cleared.
module imu_weighted_filter_integrator #(
  parameter int FILTER_TAPS = imuf_pkg::FILTER_TAPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [imuf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [imuf_pkg::GAIN_W-1:0]         cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // accel_raw_x, accel_raw_y, accel_raw_z, gyro_raw_x, gyro_raw_y, gyro_raw_z
  input  logic [imuf_pkg::IN_DATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // accel_filt_x/y/z, gyro_filt_x/y/z (16 each), angle_x/y/z (32 each)
  output logic [imuf_pkg::OUT_DATA_W-1:0]     m_tdata,
  // filter_valid
  output logic [0:0]                          m_tuser
);

  localparam int CntW = $clog2(FILTER_TAPS + 1);
  localparam int Axes = imuf_pkg::AXES;
  localparam int Gyros = imuf_pkg::GYRO_AXES;
  localparam int Sw = imuf_pkg::SAMPLE_W;
  localparam int Aw = imuf_pkg::ANGLE_W;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FILT  = 9'b000000010,
    ST_DIV   = 9'b000000100,
    ST_QUOT  = 9'b000001000,
    ST_GMUL  = 9'b000010000,
    ST_GSUM  = 9'b000100000,
    ST_INTEG = 9'b001000000,
    ST_AMUL  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [CntW-1:0] sample_count;
  logic item_valid;
  logic signed [Sw-1:0] offset [Axes];
  logic [imuf_pkg::GAIN_W-1:0] gain;

  imuf_pkg::stage_ctl_t ctl;
  logic signed [Sw-1:0] filt [Axes];
  logic signed [Aw-1:0] angle [Gyros];
  logic out_load;
  logic [Axes*Sw-1:0] filt_all;

  assign s_tready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    ctl.load = s_tvalid && s_tready;
    ctl.filt = (state == ST_FILT);
    ctl.div = (state == ST_DIV);
    ctl.quot = (state == ST_QUOT);
    ctl.gmul = (state == ST_GMUL);
    ctl.gsum = (state == ST_GSUM);
    ctl.integ = (state == ST_INTEG);
    ctl.amul = (state == ST_AMUL);
    ctl.item_valid = item_valid;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Axes; i++) begin
        offset[i] <= '0;
      end
      gain <= imuf_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        imuf_pkg::REG_ACCEL_OFFSET_X: offset[0] <= cfg_data[Sw-1:0];
        imuf_pkg::REG_ACCEL_OFFSET_Y: offset[1] <= cfg_data[Sw-1:0];
        imuf_pkg::REG_ACCEL_OFFSET_Z: offset[2] <= cfg_data[Sw-1:0];
        imuf_pkg::REG_GYRO_OFFSET_X:  offset[3] <= cfg_data[Sw-1:0];
        imuf_pkg::REG_GYRO_OFFSET_Y:  offset[4] <= cfg_data[Sw-1:0];
        imuf_pkg::REG_GYRO_OFFSET_Z:  offset[5] <= cfg_data[Sw-1:0];
        imuf_pkg::REG_INTEG_GAIN:     gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sample_count <= '0;
      item_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.load) begin
            item_valid <= (sample_count >= CntW'(FILTER_TAPS));
            if (sample_count < CntW'(FILTER_TAPS)) begin
              sample_count <= sample_count + CntW'(1);
            end
            state <= ST_FILT;
          end
        end
        ST_FILT:  state <= ST_DIV;
        ST_DIV:   state <= ST_QUOT;
        ST_QUOT:  state <= ST_GMUL;
        ST_GMUL:  state <= ST_GSUM;
        ST_GSUM:  state <= ST_INTEG;
        ST_INTEG: state <= ST_AMUL;
        ST_AMUL:  state <= ST_OUT;
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < Axes; i++) begin : g_lane
    imuf_axis_lane #(
      .FILTER_TAPS(FILTER_TAPS)
    ) u_lane (
      .clk(clk),
      .ctl(ctl),
      .raw(s_tdata[Sw*i +: Sw]),
      .offset(offset[i]),
      .filt(filt[i])
    );
    assign filt_all[Sw*i +: Sw] = filt[i];
  end

  for (genvar j = 0; j < Gyros; j++) begin : g_integ
    imuf_gyro_integ u_integ (
      .clk(clk),
      .rst(rst),
      .ctl(ctl),
      .filt(filt[Axes-Gyros+j]),
      .gain(gain),
      .angle(angle[j])
    );
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[Axes*Sw-1:0] <= filt_all;
      for (int j = 0; j < Gyros; j++) begin
        m_tdata[Axes*Sw + Aw*j +: Aw] <= angle[j];
      end
      m_tuser[0] <= item_valid;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_FILT)
    else $error("accepted sample did not start the sequence");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> sample_count == CntW'(FILTER_TAPS))
    else $error("filter_valid while history not full");

  a_zero_unfilled: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && !item_valid |-> filt_all == '0)
    else $error("filter output nonzero before history filled");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && m_tvalid && !m_tready |=> state == ST_OUT)
    else $error("result dropped while output slot busy");

endmodule

// ----- bench/tb_imu_weighted_filter_integrator.sv -----
`timescale 1ns / 100ps

module tb_imu_weighted_filter_integrator;

  localparam int TAPS = imuf_pkg::FILTER_TAPS_DEF;
  localparam int HIST = TAPS - 1;
  localparam int TAP_WEIGHT_SUM = TAPS * (TAPS + 1) / 2;
  localparam logic [imuf_pkg::CFG_INDEX_W-1:0] REG_OUT_OF_RANGE = 3'd7;
  localparam logic [imuf_pkg::SAMPLE_W-1:0] S16_MAX = 16'h7FFF;
  localparam logic [imuf_pkg::SAMPLE_W-1:0] S16_MIN = 16'h8000;
  localparam longint I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint I64_MIN = -I64_MAX - 1;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -I32_MAX - 1;
  localparam int SETTLE_CYCLES = 12;
  localparam longint CYCLE_LIMIT = 2_000_000;
  // full-scale gyro at maximum gain reaches 32-bit angle saturation in a few steps
  localparam int RAIL_ITEMS = 40;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS = 175;

  // same layout as {m_tuser, m_tdata}
  typedef struct packed {
    logic                                                      filter_valid;
    logic [imuf_pkg::GYRO_AXES-1:0][imuf_pkg::ANGLE_W-1:0]     angle;
    logic [imuf_pkg::AXES-1:0][imuf_pkg::SAMPLE_W-1:0]         filt;
  } imu_result_t;

  logic                               clk;
  logic                               rst;
  logic                               cfg_we;
  logic [imuf_pkg::CFG_INDEX_W-1:0]   cfg_index;
  logic [imuf_pkg::GAIN_W-1:0]        cfg_data;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [imuf_pkg::IN_DATA_W-1:0]     s_tdata;
  logic                               m_tvalid;
  logic                               m_tready;
  logic [imuf_pkg::OUT_DATA_W-1:0]    m_tdata;
  logic [0:0]                         m_tuser;

  imu_weighted_filter_integrator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  // predictor state
  logic signed [imuf_pkg::SAMPLE_W-1:0] offset_r [imuf_pkg::AXES];
  logic [imuf_pkg::GAIN_W-1:0]          gain_r;
  int                                   hist [imuf_pkg::AXES][HIST];
  int                                   gyro_prev [imuf_pkg::GYRO_AXES];
  longint                               integ [imuf_pkg::GYRO_AXES];
  int                                   fill_count;

  imu_result_t pending_outputs [$];
  imu_result_t got_out;
  imu_result_t want_out;

  string axis_name [imuf_pkg::AXES] =
    '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

  int     error_count = 0;
  int     samples_sent = 0;
  int     outputs_checked = 0;
  int     reg_writes = 0;
  int     rail_hits = 0;
  longint cycle_count = 0;
  bit     idle_gaps = 1'b1;
  int     stall_len;
  int     chk_i;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d outputs still pending",
             cycle_count, pending_outputs.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void model_reset();
    int a;
    int k;
    for (a = 0; a < imuf_pkg::AXES; a++) begin
      offset_r[a] = '0;
      for (k = 0; k < HIST; k++) hist[a][k] = 0;
    end
    for (a = 0; a < imuf_pkg::GYRO_AXES; a++) begin
      gyro_prev[a] = 0;
      integ[a] = 0;
    end
    gain_r = imuf_pkg::GAIN_RESET;
    fill_count = 0;
  endfunction

  // offset correction, weighted average, trapezoid integration, 0.98 scaling
  function automatic imu_result_t filter_and_integrate(
    input logic [imuf_pkg::IN_DATA_W-1:0] raw
  );
    imu_result_t r;
    int          a;
    int          k;
    int          corr;
    int          acc;
    int          filt_val [imuf_pkg::AXES];
    logic        full;
    longint      gain64;
    longint      step;
    longint      t;
    longint      p;
    r = '0;
    full = (fill_count >= TAPS);
    for (a = 0; a < imuf_pkg::AXES; a++) begin
      corr = int'($signed(raw[a*imuf_pkg::SAMPLE_W +: imuf_pkg::SAMPLE_W]))
             - int'(offset_r[a]);
      if (corr > 32767) corr = 32767;
      else if (corr < -32768) corr = -32768;
      filt_val[a] = 0;
      if (full) begin
        acc = TAPS * corr;
        for (k = 0; k < HIST; k++) acc += (TAPS - 1 - k) * hist[a][k];
        filt_val[a] = acc / TAP_WEIGHT_SUM;
      end
      for (k = HIST - 1; k > 0; k--) hist[a][k] = hist[a][k-1];
      hist[a][0] = corr;
      r.filt[a] = filt_val[a][imuf_pkg::SAMPLE_W-1:0];
    end
    gain64 = longint'({32'd0, gain_r});
    for (a = 0; a < imuf_pkg::GYRO_AXES; a++) begin
      step = longint'(filt_val[imuf_pkg::AXES-imuf_pkg::GYRO_AXES+a] + gyro_prev[a])
             * gain64;
      if (step > 0 && integ[a] > I64_MAX - step) begin
        integ[a] = I64_MAX;
        rail_hits++;
      end else if (step < 0 && integ[a] < I64_MIN - step) begin
        integ[a] = I64_MIN;
        rail_hits++;
      end else begin
        integ[a] = integ[a] + step;
      end
      gyro_prev[a] = filt_val[imuf_pkg::AXES-imuf_pkg::GYRO_AXES+a];
      t = integ[a] >>> 17;
      p = (t * longint'(imuf_pkg::ANGLE_SCALE) + 32768) >>> 16;
      if (p > I32_MAX) p = I32_MAX;
      else if (p < I32_MIN) p = I32_MIN;
      r.angle[a] = p[imuf_pkg::ANGLE_W-1:0];
    end
    if (fill_count < TAPS) fill_count++;
    r.filter_valid = full;
    return r;
  endfunction

  // all tasks below start and end just after a rising edge
  task automatic write_reg(input logic [imuf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [imuf_pkg::GAIN_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    // offset registers line up with the axis order of tdata
    if (idx <= imuf_pkg::REG_GYRO_OFFSET_Z) offset_r[idx] = value[imuf_pkg::SAMPLE_W-1:0];
    else if (idx == imuf_pkg::REG_INTEG_GAIN) gain_r = value;
    reg_writes++;
  endtask

  task automatic send_sample(input logic [imuf_pkg::IN_DATA_W-1:0] raw);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= raw;
    do @(posedge clk); while (!s_tready);
    pending_outputs.push_back(filter_and_integrate(raw));
    samples_sent++;
    gap = idle_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [imuf_pkg::SAMPLE_W-1:0] random_axis(
    input logic [imuf_pkg::SAMPLE_W-1:0] offset
  );
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return S16_MAX;
    if (r < 12) return S16_MIN;
    if (r < 40) return offset + imuf_pkg::SAMPLE_W'($urandom_range(0, 4000)) - 16'd2000;
    return imuf_pkg::SAMPLE_W'($urandom);
  endfunction

  function automatic logic [imuf_pkg::IN_DATA_W-1:0] random_sample();
    logic [imuf_pkg::IN_DATA_W-1:0] s;
    int                             a;
    for (a = 0; a < imuf_pkg::AXES; a++)
      s[a*imuf_pkg::SAMPLE_W +: imuf_pkg::SAMPLE_W] = random_axis(offset_r[a]);
    return s;
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_out = imu_result_t'({m_tuser, m_tdata});
      outputs_checked++;
      if (pending_outputs.size() == 0) begin
        report_mismatch("output transfer with nothing pending");
      end else begin
        want_out = pending_outputs.pop_front();
        for (chk_i = 0; chk_i < imuf_pkg::AXES; chk_i++)
          if (got_out.filt[chk_i] !== want_out.filt[chk_i])
            report_mismatch($sformatf("%s filtered: got %0d, want %0d", axis_name[chk_i],
                            $signed(got_out.filt[chk_i]), $signed(want_out.filt[chk_i])));
        for (chk_i = 0; chk_i < imuf_pkg::GYRO_AXES; chk_i++)
          if (got_out.angle[chk_i] !== want_out.angle[chk_i])
            report_mismatch($sformatf("angle %0d: got %0d, want %0d", chk_i,
                            $signed(got_out.angle[chk_i]), $signed(want_out.angle[chk_i])));
        if (got_out.filter_valid !== want_out.filter_valid)
          report_mismatch($sformatf("filter_valid: got %b, want %b",
                          got_out.filter_valid, want_out.filter_valid));
      end
    end
  end

  // sink side: bursts of ready with stalls, steady when gaps are off
  initial begin
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!idle_gaps) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        stall_len = pick_gap();
        if (stall_len > 0) begin
          m_tready <= 1'b0;
          repeat (stall_len) @(posedge clk);
        end
      end
    end
  end

  // default registers; zero outputs while the window fills, then full-scale data
  task automatic test_filter_fill();
    send_sample({imuf_pkg::AXES{S16_MAX}});
    send_sample({imuf_pkg::AXES{S16_MIN}});
    send_sample({imuf_pkg::AXES{16'h0000}});
    send_sample({S16_MIN, S16_MAX, 16'h0001, 16'hFFFF, 16'hAAAA, 16'h5555});
    send_sample({16'h5555, 16'hAAAA, 16'hFFFF, 16'h0001, S16_MAX, S16_MIN});
    send_sample({imuf_pkg::AXES{S16_MAX}});
    send_sample({imuf_pkg::AXES{S16_MIN}});
  endtask

  // extreme offsets drive the corrected value past both 16-bit limits;
  // upper data bits of offset writes carry junk
  task automatic test_offset_saturation();
    wait_idle();
    write_reg(imuf_pkg::REG_ACCEL_OFFSET_X, 32'hFFFF_8000);
    write_reg(imuf_pkg::REG_ACCEL_OFFSET_Y, 32'h1234_7FFF);
    write_reg(imuf_pkg::REG_ACCEL_OFFSET_Z, 32'hA5A5_0001);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_X, 32'h0001_8000);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_Y, 32'hFFFF_7FFF);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_Z, 32'h8000_FFFF);
    send_sample({imuf_pkg::AXES{S16_MAX}});
    send_sample({imuf_pkg::AXES{S16_MIN}});
    send_sample({imuf_pkg::AXES{S16_MAX}});
    send_sample({imuf_pkg::AXES{S16_MIN}});
    send_sample(random_sample());
  endtask

  task automatic test_ignored_register();
    wait_idle();
    write_reg(REG_OUT_OF_RANGE, 32'hFFFF_FFFF);
    send_sample({imuf_pkg::AXES{S16_MAX}});
    send_sample(random_sample());
    send_sample({imuf_pkg::AXES{S16_MIN}});
  endtask

  // gain of zero holds the angles; full gain pushes them into 32-bit saturation
  task automatic test_gain_extremes();
    wait_idle();
    write_reg(imuf_pkg::REG_GYRO_OFFSET_X, 32'h0000_8000);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_Y, 32'h0000_8000);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_Z, 32'h0000_8000);
    write_reg(imuf_pkg::REG_INTEG_GAIN, 32'h0000_0000);
    repeat (3) send_sample({{imuf_pkg::GYRO_AXES{S16_MAX}}, 48'h0});
    wait_idle();
    write_reg(imuf_pkg::REG_INTEG_GAIN, 32'hFFFF_FFFF);
    repeat (4) send_sample({{imuf_pkg::GYRO_AXES{S16_MAX}}, 48'h0});
    wait_idle();
    write_reg(imuf_pkg::REG_GYRO_OFFSET_X, 32'h0000_0000);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_Y, 32'h0000_0000);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_Z, 32'h0000_0000);
    repeat (3) send_sample({{imuf_pkg::GYRO_AXES{S16_MIN}}, 48'hFFFF_0000_8000});
  endtask

  // back-to-back full-scale run holds the angles in saturation, then swings back
  task automatic test_integrator_rail();
    int n;
    wait_idle();
    idle_gaps = 1'b0;
    write_reg(imuf_pkg::REG_GYRO_OFFSET_X, 32'h0000_8000);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_Y, 32'h0000_8000);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_Z, 32'h0000_8000);
    write_reg(imuf_pkg::REG_INTEG_GAIN, 32'hFFFF_FFFF);
    for (n = 0; n < RAIL_ITEMS; n++)
      send_sample({{imuf_pkg::GYRO_AXES{S16_MAX}},
                   16'($urandom), 16'($urandom), 16'($urandom)});
    wait_idle();
    write_reg(imuf_pkg::REG_GYRO_OFFSET_X, 32'h0000_7FFF);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_Y, 32'h0000_7FFF);
    write_reg(imuf_pkg::REG_GYRO_OFFSET_Z, 32'h0000_7FFF);
    repeat (20) send_sample({{imuf_pkg::GYRO_AXES{S16_MIN}},
                             16'($urandom), 16'($urandom), 16'($urandom)});
    idle_gaps = 1'b1;
  endtask

  task automatic shuffle_config();
    int                            i;
    int                            r;
    logic [imuf_pkg::SAMPLE_W-1:0] lo;
    logic [imuf_pkg::GAIN_W-1:0]   g;
    for (i = 0; i <= imuf_pkg::REG_GYRO_OFFSET_Z; i++) begin
      if ($urandom_range(0, 99) < 70) begin
        r = $urandom_range(0, 9);
        if (r < 2) lo = S16_MIN;
        else if (r < 4) lo = S16_MAX;
        else if (r < 7) lo = imuf_pkg::SAMPLE_W'($urandom_range(0, 4000)) - 16'd2000;
        else lo = imuf_pkg::SAMPLE_W'($urandom);
        write_reg(imuf_pkg::CFG_INDEX_W'(i), {16'($urandom), lo});
      end
    end
    r = $urandom_range(0, 9);
    if (r < 3) g = imuf_pkg::GAIN_RESET;
    else if (r == 3) g = '0;
    else if (r == 4) g = '1;
    else if (r < 8) g = $urandom >> $urandom_range(0, 31);
    else g = $urandom;
    write_reg(imuf_pkg::REG_INTEG_GAIN, g);
    if ($urandom_range(0, 99) < 30) write_reg(REG_OUT_OF_RANGE, $urandom);
  endtask

  task automatic test_random_stream();
    int                             phase;
    int                             n;
    logic [imuf_pkg::IN_DATA_W-1:0] held;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      shuffle_config();
      idle_gaps = (phase % 3 != 1);
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 59) == 0) wait_idle();
        if ($urandom_range(0, 19) == 0) begin
          // constant input: the average must settle to the corrected value
          held = random_sample();
          repeat (TAPS + 1) send_sample(held);
          n += TAPS + 1;
        end else begin
          send_sample(random_sample());
          n++;
        end
      end
    end
    idle_gaps = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    model_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_filter_fill();
    test_offset_saturation();
    test_ignored_register();
    test_gain_extremes();
    test_integrator_rail();
    test_random_stream();
    wait_idle();
    $display("Run: %0d samples, %0d outputs checked, %0d register writes, %0d mismatches",
             samples_sent, outputs_checked, reg_writes, error_count);
    $display("Covered filter fill, offset clamping, ignored index, gain extremes, %0d rail clamps",
             rail_hits);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
